/* rtl/mbc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_pkg
// Types, frame kind codes and parameter kind tables for the MIDI byte
// classifier.
// ----------------------------------------------------------------------------
package mbc_pkg;

    typedef logic [1:0] cnt_t;
    typedef logic [2:0] cmd_kind_t;
    typedef logic [5:0] frame_kind_t;
    typedef logic signed [4:0] chan_tag_t;

    typedef struct packed {
        logic [7:0] byte_echo;
        frame_kind_t frame_kind;
        chan_tag_t channel_tag;
    } mbc_res_t;

    localparam cnt_t CNT_FIRST  = 2'd1;
    localparam cnt_t CNT_SECOND = 2'd2;
    localparam cnt_t CNT_NONE   = 2'd3;

    localparam cmd_kind_t CMD_NONE       = 3'd0;
    localparam cmd_kind_t CMD_NOTE_OFF   = 3'd1;
    localparam cmd_kind_t CMD_NOTE_ON    = 3'd2;
    localparam cmd_kind_t CMD_AFTERTOUCH = 3'd3;
    localparam cmd_kind_t CMD_CC         = 3'd4;
    localparam cmd_kind_t CMD_PATCH      = 3'd5;
    localparam cmd_kind_t CMD_PRESSURE   = 3'd6;
    localparam cmd_kind_t CMD_PITCH_BEND = 3'd7;

    localparam frame_kind_t KIND_ERROR      = 6'd0;
    localparam frame_kind_t KIND_SYS_BASE   = 6'd8;
    localparam frame_kind_t KIND_ORPHAN     = 6'd24;
    localparam frame_kind_t KIND_KEY        = 6'd25;
    localparam frame_kind_t KIND_VELOCITY   = 6'd26;
    localparam frame_kind_t KIND_TOUCH      = 6'd27;
    localparam frame_kind_t KIND_CTRL_NUM   = 6'd28;
    localparam frame_kind_t KIND_CTRL_VAL   = 6'd29;
    localparam frame_kind_t KIND_INSTRUMENT = 6'd30;
    localparam frame_kind_t KIND_PRESSURE   = 6'd31;
    localparam frame_kind_t KIND_LSB        = 6'd32;
    localparam frame_kind_t KIND_MSB        = 6'd33;

    localparam chan_tag_t TAG_SYSTEM = -5'sd1;
    localparam chan_tag_t TAG_ORPHAN = -5'sd2;

    localparam logic [3:0] NIB_SYSTEM = 4'hF;

    function automatic frame_kind_t first_param_kind(input cmd_kind_t kind);
        frame_kind_t res;
        case (kind)
            CMD_NOTE_OFF:   res = KIND_KEY;
            CMD_NOTE_ON:    res = KIND_KEY;
            CMD_AFTERTOUCH: res = KIND_KEY;
            CMD_CC:         res = KIND_CTRL_NUM;
            CMD_PATCH:      res = KIND_INSTRUMENT;
            CMD_PRESSURE:   res = KIND_PRESSURE;
            CMD_PITCH_BEND: res = KIND_LSB;
            default:        res = KIND_ERROR;
        endcase
        return res;
    endfunction

    function automatic frame_kind_t second_param_kind(input cmd_kind_t kind);
        frame_kind_t res;
        case (kind)
            CMD_NOTE_OFF:   res = KIND_VELOCITY;
            CMD_NOTE_ON:    res = KIND_VELOCITY;
            CMD_AFTERTOUCH: res = KIND_TOUCH;
            CMD_CC:         res = KIND_CTRL_VAL;
            CMD_PITCH_BEND: res = KIND_MSB;
            default:        res = KIND_ERROR;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/mbc_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_classify
// Byte decode and command context: labels one byte and updates the stored
// command kind, channel and parameter position when the byte advances.
// ----------------------------------------------------------------------------
module mbc_classify
    import mbc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     advance,
    input  wire logic [7:0] rx_byte,
    output mbc_res_t      res
);

    cnt_t      cnt_reg;
    cnt_t      cnt_next;
    cmd_kind_t kind_reg;
    cmd_kind_t kind_next;
    logic [3:0] chan_reg;
    logic [3:0] chan_next;
    logic       is_cmd;
    logic       is_sys;

    assign is_sys = (rx_byte[7:4] == NIB_SYSTEM);
    assign is_cmd = rx_byte[7] && !is_sys;

    always_comb
    begin
        res.byte_echo   = rx_byte;
        res.frame_kind  = KIND_ORPHAN;
        res.channel_tag = TAG_ORPHAN;
        if (is_sys)
        begin
            res.frame_kind  = KIND_SYS_BASE + {2'b00, rx_byte[3:0]};
            res.channel_tag = TAG_SYSTEM;
        end
        else if (is_cmd)
        begin
            res.frame_kind  = {3'b000, rx_byte[6:4] + 3'd1};
            res.channel_tag = {1'b0, rx_byte[3:0]};
        end
        else if (cnt_reg == CNT_FIRST)
        begin
            res.frame_kind  = first_param_kind(kind_reg);
            res.channel_tag = {1'b0, chan_reg};
        end
        else if (cnt_reg == CNT_SECOND)
        begin
            res.frame_kind  = second_param_kind(kind_reg);
            res.channel_tag = {1'b0, chan_reg};
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        chan_next = chan_reg;
        if (is_cmd)
        begin
            cnt_next  = CNT_FIRST;
            kind_next = rx_byte[6:4] + 3'd1;
            chan_next = rx_byte[3:0];
        end
        else if (cnt_reg != CNT_NONE)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= CNT_NONE;
            kind_reg <= CMD_NONE;
            chan_reg <= 4'd0;
        end
        else if (advance)
        begin
            cnt_reg  <= cnt_next;
            kind_reg <= kind_next;
            chan_reg <= chan_next;
        end
    end

`ifndef ASSERT_OFF
    a_cmd_sets_first: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_cmd |=> cnt_reg == CNT_FIRST)
        else $error("command byte did not set first parameter position");

    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != CNT_NONE |-> kind_reg != CMD_NONE)
        else $error("parameter position active without stored command");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_cmd && cnt_reg == CNT_NONE |=> cnt_reg == CNT_NONE)
        else $error("position counter left saturation without command");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(cnt_reg) && $stable(kind_reg) && $stable(chan_reg))
        else $error("command context changed without an advancing byte");
`endif

endmodule
`default_nettype wire

/* rtl/midi_byte_classifier_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// midi_byte_classifier_core
// Stream front end: input byte register, classifier and result register.
// ----------------------------------------------------------------------------
// Path: an accepted byte goes through the input byte register, the classifier and the result register.
// Throughput: one byte per cycle; set by the input and result registers,
// which both advance whenever the result side can take a word.
// Reset: asynchronous; empties both registers and clears the command
// context to "no command seen".
module midi_byte_classifier_core
    import mbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] byte_echo, [12:8] channel_tag
    output logic [5:0]       m_axis_tuser    // [5:0] frame_kind
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    mbc_res_t   out_res_reg;
    mbc_res_t   res;
    logic       out_open;
    logic       advance;

    assign out_open      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_open;
    assign s_axis_tready = !in_valid_reg || out_open;

    mbc_classify u_classify (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_open)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg.channel_tag, out_res_reg.byte_echo};
    assign m_axis_tuser  = out_res_reg.frame_kind;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the MIDI byte classifier. Bytes go in through the
// slave stream while a tracker keeps its own command context and lists the
// label each byte should get. Labels coming out of the master stream are
// matched against that list in order. Stimulus: a walk through the command
// and system bytes and the parameter slots, then random messages with
// stray system and noise bytes, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbc_pkg::*;

    localparam int BYTE_COUNT  = 1750;
    localparam int HOLD_CYCLES = 64;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [7:0] OPENING [0:26] = '{
        8'h00, 8'h7F, 8'h80, 8'h00, 8'h7F, 8'h55, 8'h9F, 8'hF8, 8'h40,
        8'hA3, 8'h11, 8'h22, 8'hB5, 8'h01, 8'h02, 8'hC7, 8'h10, 8'h20,
        8'hD1, 8'h30, 8'h31, 8'hE2, 8'h00, 8'h7F, 8'hFF, 8'hF0, 8'h01
    };

    class midi_label_tracker;
        mbc_res_t    labels_due[$];
        cnt_t        slot;
        cmd_kind_t   cmd;
        logic [3:0]  chan;
        int          faults;

        function new();
            slot   = CNT_NONE;
            cmd    = CMD_NONE;
            chan   = 4'd0;
            faults = 0;
        endfunction

        function frame_kind_t param_label(input cmd_kind_t k, input bit second);
            frame_kind_t res;
            res = KIND_ERROR;
            case (k)
                CMD_NOTE_OFF, CMD_NOTE_ON: res = second ? KIND_VELOCITY : KIND_KEY;
                CMD_AFTERTOUCH:            res = second ? KIND_TOUCH : KIND_KEY;
                CMD_CC:                    res = second ? KIND_CTRL_VAL : KIND_CTRL_NUM;
                CMD_PATCH:                 res = second ? KIND_ERROR : KIND_INSTRUMENT;
                CMD_PRESSURE:              res = second ? KIND_ERROR : KIND_PRESSURE;
                CMD_PITCH_BEND:            res = second ? KIND_MSB : KIND_LSB;
                default:                   res = KIND_ERROR;
            endcase
            return res;
        endfunction

        function void take_byte(input logic [7:0] b);
            mbc_res_t lbl;
            bit       is_cmd;
            is_cmd = 1'b0;
            lbl.byte_echo = b;
            if (b[7] && b[7:4] == NIB_SYSTEM) begin
                lbl.frame_kind  = KIND_SYS_BASE + frame_kind_t'(b[3:0]);
                lbl.channel_tag = TAG_SYSTEM;
            end else if (b[7]) begin
                cmd    = cmd_kind_t'(b[6:4] + 3'd1);
                chan   = b[3:0];
                is_cmd = 1'b1;
                lbl.frame_kind  = frame_kind_t'(cmd);
                lbl.channel_tag = chan_tag_t'({1'b0, chan});
            end else if (slot == CNT_FIRST || slot == CNT_SECOND) begin
                lbl.frame_kind  = param_label(cmd, slot == CNT_SECOND);
                lbl.channel_tag = chan_tag_t'({1'b0, chan});
            end else begin
                lbl.frame_kind  = KIND_ORPHAN;
                lbl.channel_tag = TAG_ORPHAN;
            end
            if (is_cmd)
                slot = CNT_FIRST;
            else if (slot != CNT_NONE)
                slot = slot + 2'd1;
            labels_due.push_back(lbl);
        endfunction

        function void match_label(input logic [7:0] echo, input frame_kind_t kind,
                                  input chan_tag_t tag);
            mbc_res_t want;
            if (labels_due.size() == 0) begin
                $error("unexpected word: byte_echo %h frame_kind %0d", echo, kind);
                faults++;
                return;
            end
            want = labels_due.pop_front();
            if (echo !== want.byte_echo) begin
                $error("byte_echo expected %h actual %h", want.byte_echo, echo);
                faults++;
            end
            if (kind !== want.frame_kind) begin
                $error("frame_kind expected %0d actual %0d", want.frame_kind, kind);
                faults++;
            end
            if (tag !== want.channel_tag) begin
                $error("channel_tag expected %0d actual %0d",
                       want.channel_tag, tag);
                faults++;
            end
        endfunction

        function int pending();
            return labels_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;

    midi_label_tracker tracker = new();

    bit quiet        = 1'b0;
    bit hold_off_req = 1'b0;
    int sent         = 0;
    int cycles       = 0;

    midi_byte_classifier_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_label(m_axis_tdata[7:0], frame_kind_t'(m_axis_tuser),
                                chan_tag_t'(m_axis_tdata[12:8]));
    end

    // result side: random stall bursts, one long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        tracker.take_byte(b);
        sent++;
    endtask

    task automatic feed_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        send_byte(b);
    endtask

    task automatic drain_labels();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic play_message();
        logic [7:0] status;
        int         n_data;
        status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
        n_data = (status[7:4] == 4'hC || status[7:4] == 4'hD) ? 1 : 2;
        if ($urandom_range(0, 4) == 0)
            n_data = $urandom_range(0, 4);
        feed_byte(status);
        for (int i = 0; i < n_data; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                feed_byte({NIB_SYSTEM, 4'($urandom_range(0, 15))});
            feed_byte(8'($urandom_range(0, 127)));
        end
    endtask

    initial
    begin
        bit hold_done;
        bit drain_done;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (OPENING[i])
            feed_byte(OPENING[i]);
        drain_labels();

        while (sent < BYTE_COUNT)
        begin
            if (!hold_done && sent > 600)
            begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && sent > 1100)
            begin
                drain_labels();
                drain_done = 1'b1;
            end
            if (sent > 1500)
                quiet = 1'b1;
            if ($urandom_range(0, 7) == 0)
                feed_byte(8'($urandom_range(0, 255)));
            else
                play_message();
        end

        drain_labels();
        repeat (8) @(posedge clk);
        if (tracker.faults == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

/* midi_byte_classifier_core.f */
rtl/mbc_pkg.sv
rtl/mbc_classify.sv
rtl/midi_byte_classifier_core.sv
tb/tb_top.sv
